[rtl/rfcp_pkg.sv]
// Shared types and constants for the rectangle fill burst planner.
package rfcp_pkg;

    // Width of pixel totals, remaining counts, burst capacity and row quotients.
    localparam int CNT_W = 17;

    // Number of restoring divide steps, one quotient bit each.
    localparam int DIV_STEPS = CNT_W;

    // Index of the final burst allowed for one request.
    localparam logic [5:0] LAST_BURST_IDX = 6'd63;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    // One accepted request, ready to be split into bursts.
    typedef struct packed {
        logic [8:0]       rx;
        logic [8:0]       rw;
        logic [7:0]       ry;
        logic [7:0]       rh;
        logic [15:0]      c565;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] cap_rows;
        logic [8:0]       cap_cols;
    } req_t;

endpackage

[rtl/rfcp_front.sv]
// Request intake: screen checks, color packing and the capacity-per-row divider.
module rfcp_front #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int BUFFER_BYTES  = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [23:0]         color_rgb888,
    input  logic [8:0]          rect_x,
    input  logic [8:0]          rect_width,
    input  logic [7:0]          rect_y,
    input  logic [7:0]          rect_height,
    output logic                push_valid,
    input  logic                push_stall,
    output rfcp_pkg::req_t      push_data
);

    localparam int CAP_INT = (BUFFER_BYTES / 2 == 0) ? 1 : BUFFER_BYTES / 2;
    localparam logic [rfcp_pkg::CNT_W-1:0] CAP = rfcp_pkg::CNT_W'(CAP_INT);
    localparam logic [10:0] SW_L = 11'(SCREEN_WIDTH);
    localparam logic [10:0] SH_L = 11'(SCREEN_HEIGHT);
    localparam logic [4:0]  LAST_STEP = 5'(rfcp_pkg::DIV_STEPS - 1);

    rfcp_pkg::front_state_t state_reg, state_next;
    rfcp_pkg::req_t req_reg, req_next;
    logic [8:0]                  rem_reg, rem_next;
    logic [rfcp_pkg::CNT_W-1:0]  dvd_reg, dvd_next;
    logic [rfcp_pkg::CNT_W-1:0]  quo_reg, quo_next;
    logic [4:0]                  cnt_reg, cnt_next;

    logic        accept;
    logic        fits;
    logic        nonempty;
    logic [9:0]  trial;
    logic        take;

    assign req_stall = (state_reg != rfcp_pkg::F_IDLE);
    assign accept    = req_valid && !req_stall;

    assign fits = (({2'b0, rect_x} + {2'b0, rect_width}) <= SW_L) &&
                  (({3'b0, rect_y} + {3'b0, rect_height}) <= SH_L);
    assign nonempty = (rect_width != 9'd0) && (rect_height != 8'd0);

    assign trial = {rem_reg, dvd_reg[rfcp_pkg::CNT_W-1]};
    assign take  = (trial >= {1'b0, req_reg.rw});

    assign push_valid = (state_reg == rfcp_pkg::F_PUSH);
    assign push_data  = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfcp_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            rfcp_pkg::F_IDLE:
            begin
                if (accept && fits && nonempty)
                begin
                    req_next.rx       = rect_x;
                    req_next.rw       = rect_width;
                    req_next.ry       = rect_y;
                    req_next.rh       = rect_height;
                    req_next.c565     = {color_rgb888[23:19], color_rgb888[15:10],
                                         color_rgb888[7:3]};
                    req_next.total    = {8'b0, rect_width} * {9'b0, rect_height};
                    req_next.cap_rows = '0;
                    req_next.cap_cols = '0;
                    rem_next   = '0;
                    dvd_next   = CAP;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = rfcp_pkg::F_DIV;
                end
            end
            rfcp_pkg::F_DIV:
            begin
                // Restoring division of the burst capacity by the width.
                rem_next = take ? 9'(trial - {1'b0, req_reg.rw}) : trial[8:0];
                quo_next = {quo_reg[rfcp_pkg::CNT_W-2:0], take};
                dvd_next = {dvd_reg[rfcp_pkg::CNT_W-2:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    req_next.cap_rows = quo_next;
                    req_next.cap_cols = rem_next;
                    state_next = rfcp_pkg::F_PUSH;
                end
            end
            rfcp_pkg::F_PUSH:
            begin
                if (!push_stall)
                begin
                    state_next = rfcp_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = rfcp_pkg::F_IDLE;
            end
        endcase
    end

endmodule

[rtl/rfcp_queue.sv]
// Two-entry request queue between intake and burst generation.
module rfcp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_stall,
    input  rfcp_pkg::req_t push_data,
    output logic           pop_valid,
    input  logic           pop_stall,
    output rfcp_pkg::req_t pop_data
);

    rfcp_pkg::req_t mem [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push;
    logic       pop;

    assign push_stall = (count_reg == 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/rfcp_back.sv]
// Burst sequencer: walks one request and drives the registered burst output.
module rfcp_back #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int BUFFER_BYTES  = 16384
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_stall,
    input  rfcp_pkg::req_t pop_data,
    output logic           burst_valid,
    input  logic           burst_stall,
    output logic [8:0]     win_x1,
    output logic [8:0]     win_x2,
    output logic [7:0]     win_y1,
    output logic [7:0]     win_y2,
    output logic [13:0]    pixel_count,
    output logic [15:0]    color_rgb565,
    output logic           last_burst
);

    localparam int CAP_INT = (BUFFER_BYTES / 2 == 0) ? 1 : BUFFER_BYTES / 2;
    localparam logic [rfcp_pkg::CNT_W-1:0] CAP = rfcp_pkg::CNT_W'(CAP_INT);
    localparam logic [10:0] X_MAX = 11'(SCREEN_WIDTH - 1);
    localparam logic [10:0] Y_MAX = 11'(SCREEN_HEIGHT - 1);

    rfcp_pkg::back_state_t state_reg, state_next;
    rfcp_pkg::req_t cur_reg, cur_next;
    logic [9:0]                 x1_reg, x1_next;
    logic [8:0]                 y1_reg, y1_next;
    logic [rfcp_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [5:0]                 n_reg, n_next;

    logic        out_valid_reg, out_valid_next;
    logic [8:0]  x1_out_reg, x1_out_next;
    logic [8:0]  x2_out_reg, x2_out_next;
    logic [7:0]  y1_out_reg, y1_out_next;
    logic [7:0]  y2_out_reg, y2_out_next;
    logic [13:0] cnt_out_reg, cnt_out_next;
    logic [15:0] col_out_reg, col_out_next;
    logic        last_out_reg, last_out_next;

    logic                       emit;
    logic                       at_start;
    logic                       capped;
    logic [rfcp_pkg::CNT_W-1:0] npix;
    logic [rfcp_pkg::CNT_W-1:0] rem_after;
    logic [9:0]                 row_end;
    logic [10:0]                x2_raw;
    logic [10:0]                y2_raw;
    logic                       is_last;
    logic [9:0]                 x1_step;
    logic [8:0]                 y1_step;

    assign pop_stall = (state_reg != rfcp_pkg::B_IDLE);
    assign emit = (state_reg == rfcp_pkg::B_RUN) && (!out_valid_reg || !burst_stall);

    assign at_start = (x1_reg == {1'b0, cur_reg.rx});
    assign capped   = (rem_reg > CAP);
    assign row_end  = {1'b0, cur_reg.rx} + {1'b0, cur_reg.rw};
    assign x2_raw   = {1'b0, x1_reg} + {2'b0, cur_reg.rw} - 11'd1;
    assign y2_raw   = {2'b0, y1_reg} + {3'b0, cur_reg.rh} - 11'd1;

    always_comb
    begin
        if (at_start)
        begin
            npix = capped ? CAP : rem_reg;
            // A full burst from a row start lands cap_rows rows down, cap_cols in.
            x1_step = {1'b0, cur_reg.rx} + {1'b0, cur_reg.cap_cols};
            y1_step = 9'({8'b0, y1_reg} + cur_reg.cap_rows);
        end
        else
        begin
            // Mid-row start: finish the row, then resume at the left edge.
            npix = rfcp_pkg::CNT_W'(row_end - x1_reg);
            x1_step = {1'b0, cur_reg.rx};
            y1_step = y1_reg + 9'd1;
        end
        rem_after = rem_reg - npix;
        is_last   = (rem_after == '0) || (n_reg == rfcp_pkg::LAST_BURST_IDX);
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        rem_next       = rem_reg;
        n_next         = n_reg;
        out_valid_next = (out_valid_reg && burst_stall) || emit;
        x1_out_next    = x1_out_reg;
        x2_out_next    = x2_out_reg;
        y1_out_next    = y1_out_reg;
        y2_out_next    = y2_out_reg;
        cnt_out_next   = cnt_out_reg;
        col_out_next   = col_out_reg;
        last_out_next  = last_out_reg;
        unique case (state_reg)
            rfcp_pkg::B_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_next   = pop_data;
                    x1_next    = {1'b0, pop_data.rx};
                    y1_next    = {1'b0, pop_data.ry};
                    rem_next   = pop_data.total;
                    n_next     = '0;
                    state_next = rfcp_pkg::B_RUN;
                end
            end
            rfcp_pkg::B_RUN:
            begin
                if (emit)
                begin
                    x1_out_next  = x1_reg[8:0];
                    x2_out_next  = (x2_raw > X_MAX) ? X_MAX[8:0] : x2_raw[8:0];
                    y1_out_next  = y1_reg[7:0];
                    y2_out_next  = (y2_raw > Y_MAX) ? Y_MAX[7:0] : y2_raw[7:0];
                    cnt_out_next = npix[13:0];
                    col_out_next = cur_reg.c565;
                    last_out_next = is_last;
                    x1_next  = x1_step;
                    y1_next  = y1_step;
                    rem_next = rem_after;
                    n_next   = n_reg + 6'd1;
                    if (is_last)
                    begin
                        state_next = rfcp_pkg::B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rfcp_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfcp_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        rem_reg      <= rem_next;
        n_reg        <= n_next;
        x1_out_reg   <= x1_out_next;
        x2_out_reg   <= x2_out_next;
        y1_out_reg   <= y1_out_next;
        y2_out_reg   <= y2_out_next;
        cnt_out_reg  <= cnt_out_next;
        col_out_reg  <= col_out_next;
        last_out_reg <= last_out_next;
    end

    assign burst_valid  = out_valid_reg;
    assign win_x1       = x1_out_reg;
    assign win_x2       = x2_out_reg;
    assign win_y1       = y1_out_reg;
    assign win_y2       = y2_out_reg;
    assign pixel_count  = cnt_out_reg;
    assign color_rgb565 = col_out_reg;
    assign last_burst   = last_out_reg;

endmodule

[rtl/rect_fill_chunk_planner.sv]
// An accepted request is divided, pushed to the queue, then taken by the burst sequencer.
// Intake takes no new request until the current one is divided and pushed to the queue.
// The burst sequencer produces one burst per cycle within a request while the output is not stalled.
// Rejected or empty rectangles are dropped at intake, which stays idle for the next request.
// Reset (rst_n low, asynchronous) empties the queue and clears every valid.
module rect_fill_chunk_planner #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int BUFFER_BYTES  = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [23:0] color_rgb888,
    input  logic [8:0]  rect_x,
    input  logic [8:0]  rect_width,
    input  logic [7:0]  rect_y,
    input  logic [7:0]  rect_height,
    output logic        burst_valid,
    input  logic        burst_stall,
    output logic [8:0]  win_x1,
    output logic [8:0]  win_x2,
    output logic [7:0]  win_y1,
    output logic [7:0]  win_y2,
    output logic [13:0] pixel_count,
    output logic [15:0] color_rgb565,
    output logic        last_burst
);

    // The front checks a request against the screen, packs the color and divides
    // the burst capacity by the rectangle width. That quotient and remainder tell
    // the back how far a full burst moves from a row start, so the back never
    // divides: it only adds, compares and subtracts per burst.

    logic           push_valid;
    logic           push_stall;
    rfcp_pkg::req_t push_data;
    logic           pop_valid;
    logic           pop_stall;
    rfcp_pkg::req_t pop_data;

    rfcp_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .color_rgb888 (color_rgb888),
        .rect_x       (rect_x),
        .rect_width   (rect_width),
        .rect_y       (rect_y),
        .rect_height  (rect_height),
        .push_valid   (push_valid),
        .push_stall   (push_stall),
        .push_data    (push_data)
    );

    // The queue lets the front take the next transfer while bursts still drain.
    rfcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_data   (pop_data)
    );

    rfcp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_stall    (pop_stall),
        .pop_data     (pop_data),
        .burst_valid  (burst_valid),
        .burst_stall  (burst_stall),
        .win_x1       (win_x1),
        .win_x2       (win_x2),
        .win_y1       (win_y1),
        .win_y2       (win_y2),
        .pixel_count  (pixel_count),
        .color_rgb565 (color_rgb565),
        .last_burst   (last_burst)
    );

endmodule
